/* hw/rtl/srtq_pkg.sv */
// ----------------------------------------------------------------------------
// srtq_pkg
// Types, codes and helpers shared by the sorted repeating timer queue.
// ----------------------------------------------------------------------------
package srtq_pkg;

  localparam int unsigned TimerSlotsDef = 16;
  localparam int unsigned MaxFire       = 16;
  localparam int unsigned FireW         = 5;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_RUN    = 3'd2,
    CMD_SETLEN = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_QUERY  = 3'd5,
    CMD_CLEAR  = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_NONE      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SCAN_FREE,
    SCAN_ID,
    SCAN_HEAD,
    SCAN_COUNT
  } scan_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_EMIT,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic [31:0]        ident;
    logic [47:0]        expiry;
    logic signed [48:0] period;
    logic signed [31:0] repeats;
    logic [47:0]        last_start;
    logic [31:0]        order;
  } entry_t;

  typedef struct packed {
    logic       clear;
    logic       step;
    scan_mode_e mode;
  } scan_ctrl_t;

  // start + length, saturated to the 48-bit time range
  function automatic logic [47:0] arm_expiry(logic [47:0] start, logic signed [48:0] per);
    logic [49:0] sum;
    sum = {2'b00, start} + {per[48], per};
    if (sum[49]) begin
      arm_expiry = '0;
    end else if (sum[48]) begin
      arm_expiry = '1;
    end else begin
      arm_expiry = sum[47:0];
    end
  endfunction

endpackage

/* hw/rtl/srtq_ram.sv */
// ----------------------------------------------------------------------------
// srtq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/srtq_scan.sv */
// ----------------------------------------------------------------------------
// srtq_scan
// Shared compare unit: one slot per step, keeps the best match of a sweep or counts expired slots.
// ----------------------------------------------------------------------------
module srtq_scan #(
  parameter int unsigned TimerSlots = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srtq_pkg::scan_ctrl_t          ctrl_i,
  input  logic [$clog2(TimerSlots)-1:0] idx_i,
  input  srtq_pkg::entry_t              ent_i,
  input  logic                          valid_i,
  input  logic                          inactive_i,
  input  logic [31:0]                   id_i,
  input  logic [47:0]                   now_i,
  input  logic [31:0]                   order_ctr_i,
  output logic                          found_o,
  output logic [$clog2(TimerSlots)-1:0] best_idx_o,
  output srtq_pkg::entry_t              best_ent_o,
  output logic [srtq_pkg::FireW-1:0]    count_o
);
  import srtq_pkg::*;

  localparam int unsigned IdxW = $clog2(TimerSlots);

  logic             found_q, found_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  entry_t           ent_q, ent_d;
  logic [31:0]      age_q, age_d;
  logic [FireW-1:0] cnt_q, cnt_d;
  logic [31:0]      age;
  logic             live;

  assign age  = order_ctr_i - ent_i.order;
  assign live = valid_i && !inactive_i;

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    ent_d   = ent_q;
    age_d   = age_q;
    cnt_d   = cnt_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
      cnt_d   = '0;
    end else if (ctrl_i.step) begin
      case (ctrl_i.mode)
        SCAN_FREE: begin
          if (!found_q && !valid_i) begin
            found_d = 1'b1;
            idx_d   = idx_i;
          end
        end
        SCAN_ID: begin
          if (!found_q && valid_i && id_i != '0 && ent_i.ident == id_i) begin
            found_d = 1'b1;
            idx_d   = idx_i;
            ent_d   = ent_i;
          end
        end
        SCAN_HEAD: begin
          // earlier expiry wins; on a tie the older stamp wins
          if (live && (!found_q || ent_i.expiry < ent_q.expiry ||
                       (ent_i.expiry == ent_q.expiry && age > age_q))) begin
            found_d = 1'b1;
            idx_d   = idx_i;
            ent_d   = ent_i;
            age_d   = age;
          end
        end
        SCAN_COUNT: begin
          if (live && ent_i.expiry <= now_i && cnt_q != FireW'(MaxFire)) begin
            cnt_d = cnt_q + FireW'(1);
          end
        end
        default: begin
          found_d = found_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      found_q <= found_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ent_q <= ent_d;
    age_q <= age_d;
  end

  assign found_o    = found_q;
  assign best_idx_o = idx_q;
  assign best_ent_o = ent_q;
  assign count_o    = cnt_q;

endmodule

/* hw/rtl/sorted_repeating_timer_queue.sv */
// ----------------------------------------------------------------------------
// sorted_repeating_timer_queue
// Timer table ordered by expiry; commands swept over the slot RAM.
// ----------------------------------------------------------------------------
// Sweeps: clear and no-op commands skip the slot RAM; create, delete, query, set
//   length and time to next take one slot RAM sweep.
// Run: one sweep to count expired timers plus one sweep per fired timer. One request at a time.
// Reset: all slots empty, next id 1, order stamp 0; no clearing pass.
module sorted_repeating_timer_queue #(
  parameter int unsigned TIMER_SLOTS = srtq_pkg::TimerSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        timer_id_i,
  input  logic [47:0]        time_now_i,
  input  logic signed [48:0] period_length_i,
  input  logic signed [31:0] repeat_budget_i,
  input  logic               use_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        result_id_o,
  output logic [1:0]         status_o,
  output logic signed [48:0] time_left_o,
  output logic               last_o
);
  import srtq_pkg::*;

  localparam int unsigned IdxW = $clog2(TIMER_SLOTS);
  localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1);

  fsm_e state_q, state_d, ret_q, ret_d;

  cmd_e               func_q, func_d;
  logic [31:0]        id_q, id_d;
  logic [47:0]        now_q, now_d;
  logic signed [48:0] per_q, per_d;
  logic signed [31:0] rep_q, rep_d;
  logic               use_q, use_d;

  logic [CntW-1:0] scan_q, scan_d;
  logic            dv_q, dv_d;
  logic [IdxW-1:0] didx_q, didx_d;
  scan_mode_e      mode_q, mode_d;
  logic            run_head_q, run_head_d;
  logic [FireW-1:0] fire_q, fire_d, lim_q, lim_d;
  logic            pend_v_q, pend_v_d;
  logic [31:0]     pend_id_q, pend_id_d;

  logic [TIMER_SLOTS-1:0] valid_q, valid_d, inact_q, inact_d;
  logic [31:0]     next_id_q, next_id_d, order_q, order_d;

  logic [31:0]        res_id_q, res_id_d;
  status_e            res_st_q, res_st_d;
  logic signed [48:0] res_tl_q, res_tl_d;
  logic               res_last_q, res_last_d;
  logic               out_v_q, out_v_d;

  logic            rd_en, we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata, rd_ent, best_ent;
  logic [$bits(entry_t)-1:0] rd_raw;
  logic            found, scan_start;
  logic [IdxW-1:0] best_idx;
  logic [FireW-1:0] exp_cnt;
  scan_ctrl_t      sctl;
  logic            out_free;

  assign rd_en  = (state_q == S_SCAN) && (scan_q < CntW'(TIMER_SLOTS));
  assign rd_ent = entry_t'(rd_raw);

  srtq_ram #(
    .Width ($bits(entry_t)),
    .Depth (TIMER_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (rd_raw)
  );

  assign sctl.clear = scan_start;
  assign sctl.step  = (state_q == S_SCAN) && dv_q;
  assign sctl.mode  = mode_q;

  srtq_scan #(
    .TimerSlots (TIMER_SLOTS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sctl),
    .idx_i       (didx_q),
    .ent_i       (rd_ent),
    .valid_i     (valid_q[didx_q]),
    .inactive_i  (inact_q[didx_q]),
    .id_i        (id_q),
    .now_i       (now_q),
    .order_ctr_i (order_q),
    .found_o     (found),
    .best_idx_o  (best_idx),
    .best_ent_o  (best_ent),
    .count_o     (exp_cnt)
  );

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    func_d     = func_q;
    id_d       = id_q;
    now_d      = now_q;
    per_d      = per_q;
    rep_d      = rep_q;
    use_d      = use_q;
    scan_d     = scan_q;
    dv_d       = 1'b0;
    didx_d     = scan_q[IdxW-1:0];
    mode_d     = mode_q;
    run_head_d = run_head_q;
    fire_d     = fire_q;
    lim_d      = lim_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    valid_d    = valid_q;
    inact_d    = inact_q;
    next_id_d  = next_id_q;
    order_d    = order_q;
    res_id_d   = res_id_q;
    res_st_d   = res_st_q;
    res_tl_d   = res_tl_q;
    res_last_d = res_last_q;
    out_v_d    = out_v_q && !out_ready_i;
    scan_start = 1'b0;
    we         = 1'b0;
    waddr      = best_idx;
    wdata      = best_ent;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d     = cmd_e'(func_i);
          id_d       = timer_id_i;
          now_d      = time_now_i;
          per_d      = period_length_i;
          rep_d      = repeat_budget_i;
          use_d      = use_start_i;
          run_head_d = 1'b0;
          fire_d     = '0;
          pend_v_d   = 1'b0;
          res_id_d   = '0;
          res_st_d   = STS_OK;
          res_tl_d   = '0;
          res_last_d = 1'b1;
          case (cmd_e'(func_i))
            CMD_CREATE: mode_d = SCAN_FREE;
            CMD_RUN:    mode_d = SCAN_COUNT;
            CMD_NEXT:   mode_d = SCAN_HEAD;
            default:    mode_d = SCAN_ID;
          endcase
          if (cmd_e'(func_i) == CMD_CLEAR || cmd_e'(func_i) == CMD_NOP) begin
            state_d = S_ACT;
          end else begin
            state_d    = S_SCAN;
            scan_start = 1'b1;
            scan_d     = '0;
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          scan_d = scan_q + CntW'(1);
          dv_d   = 1'b1;
        end else if (!dv_q) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_EMIT;
        ret_d   = S_IDLE;
        case (func_q)
          CMD_CREATE: begin
            if (found) begin
              we               = 1'b1;
              wdata.ident      = next_id_q;
              wdata.period     = per_q;
              wdata.repeats    = rep_q;
              wdata.last_start = now_q;
              wdata.expiry     = arm_expiry(now_q, per_q);
              wdata.order      = order_q;
              valid_d[best_idx] = 1'b1;
              inact_d[best_idx] = (per_q == '1);
              order_d   = order_q + 32'd1;
              res_id_d  = next_id_q;
              next_id_d = (next_id_q == '1) ? 32'd1 : next_id_q + 32'd1;
            end else begin
              res_st_d = STS_FULL;
            end
          end
          CMD_DELETE, CMD_QUERY, CMD_SETLEN: begin
            if (found) begin
              res_id_d = id_q;
              if (func_q == CMD_DELETE) begin
                valid_d[best_idx] = 1'b0;
              end
              if (func_q == CMD_SETLEN) begin
                we               = 1'b1;
                wdata.period     = per_q;
                wdata.last_start = use_q ? now_q : best_ent.last_start;
                wdata.expiry     = arm_expiry(wdata.last_start, per_q);
                wdata.order      = order_q;
                inact_d[best_idx] = (per_q == '1);
                order_d = order_q + 32'd1;
              end
            end else begin
              res_st_d = STS_NOT_FOUND;
            end
          end
          CMD_NEXT: begin
            if (found) begin
              res_tl_d = (best_ent.expiry > now_q) ?
                         {1'b0, best_ent.expiry - now_q} : '0;
            end else begin
              res_st_d = STS_NONE;
              res_tl_d = '1;
            end
          end
          CMD_RUN: begin
            if (!run_head_q) begin
              lim_d = exp_cnt;
              if (exp_cnt == '0) begin
                state_d = S_FINISH;
              end else begin
                run_head_d = 1'b1;
                mode_d     = SCAN_HEAD;
                state_d    = S_SCAN;
                scan_start = 1'b1;
                scan_d     = '0;
              end
            end else if (found && best_ent.expiry <= now_q) begin
              fire_d = fire_q + FireW'(1);
              wdata.last_start = now_q;
              if (best_ent.repeats == '0) begin
                valid_d[best_idx] = 1'b0;
              end else begin
                we = 1'b1;
                if (best_ent.repeats > 0) begin
                  wdata.repeats = best_ent.repeats - 32'sd1;
                end
                wdata.expiry = arm_expiry(now_q, best_ent.period);
                wdata.order  = order_q;
                inact_d[best_idx] = (best_ent.period == '1);
                order_d = order_q + 32'd1;
              end
              pend_v_d  = 1'b1;
              pend_id_d = best_ent.ident;
              // the previous fired id goes out once a later one is known
              ret_d = (fire_d < lim_q) ? S_SCAN : S_FINISH;
              if (pend_v_q) begin
                res_id_d   = pend_id_q;
                res_last_d = 1'b0;
              end else begin
                state_d = ret_d;
                if (ret_d == S_SCAN) begin
                  scan_start = 1'b1;
                  scan_d     = '0;
                end
              end
            end else begin
              state_d = S_FINISH;
            end
          end
          CMD_CLEAR: begin
            valid_d = '0;
            inact_d = '0;
          end
          default: begin
            res_st_d = STS_OK;
          end
        endcase
      end
      S_FINISH: begin
        state_d    = S_EMIT;
        ret_d      = S_IDLE;
        res_last_d = 1'b1;
        res_tl_d   = '0;
        if (pend_v_q) begin
          res_id_d = pend_id_q;
          res_st_d = STS_OK;
        end else begin
          res_id_d = '0;
          res_st_d = STS_NONE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          state_d = ret_q;
          if (ret_q == S_SCAN) begin
            scan_start = 1'b1;
            scan_d     = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      dv_q       <= 1'b0;
      run_head_q <= 1'b0;
      fire_q     <= '0;
      pend_v_q   <= 1'b0;
      valid_q    <= '0;
      inact_q    <= '0;
      next_id_q  <= 32'd1;
      order_q    <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      dv_q       <= dv_d;
      run_head_q <= run_head_d;
      fire_q     <= fire_d;
      pend_v_q   <= pend_v_d;
      valid_q    <= valid_d;
      inact_q    <= inact_d;
      next_id_q  <= next_id_d;
      order_q    <= order_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    id_q       <= id_d;
    now_q      <= now_d;
    per_q      <= per_d;
    rep_q      <= rep_d;
    use_q      <= use_d;
    scan_q     <= scan_d;
    didx_q     <= didx_d;
    mode_q     <= mode_d;
    lim_q      <= lim_d;
    pend_id_q  <= pend_id_d;
    res_id_q   <= res_id_d;
    res_st_q   <= res_st_d;
    res_tl_q   <= res_tl_d;
    res_last_q <= res_last_d;
    if (state_q == S_EMIT && out_free) begin
      result_id_o <= res_id_q;
      status_o    <= res_st_q;
      time_left_o <= res_tl_q;
      last_o      <= res_last_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_pending_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q && state_q != S_IDLE |-> func_q == CMD_RUN)
    else $error("pending fired id outside a run");

  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_head_q && state_q != S_IDLE |-> fire_q <= lim_q)
    else $error("more timers fired than were expired");

  a_emit_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && out_free |=> out_v_q)
    else $error("result dropped at output register");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the sorted repeating timer queue, predicts every result
// with a behavioral timer table and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import srtq_pkg::*;

  localparam int Slots = 16;
  localparam logic [47:0] TMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0]        rid;
    logic [1:0]         sts;
    logic signed [48:0] tleft;
    logic               lst;
  } timer_rsp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         func_i = '0;
  logic [31:0]        timer_id_i = '0;
  logic [47:0]        time_now_i = '0;
  logic signed [48:0] period_length_i = '0;
  logic signed [31:0] repeat_budget_i = '0;
  logic               use_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        result_id_o;
  logic [1:0]         status_o;
  logic signed [48:0] time_left_o;
  logic               last_o;

  sorted_repeating_timer_queue DUT (.*);

  // timer table copy
  bit                 tv [Slots];
  bit                 tina [Slots];
  logic [31:0]        tid [Slots];
  logic [47:0]        texp [Slots];
  logic signed [48:0] tper [Slots];
  logic signed [31:0] treps [Slots];
  logic [47:0]        tstart [Slots];
  logic [31:0]        tstamp [Slots];
  logic [31:0]        id_next;
  logic [31:0]        stamp_ctr;

  timer_rsp_t expected_rsp [$];
  int errors = 0;
  int n_reqs = 0;
  int n_rsps = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fired_total = 0;

  initial forever #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_rsps);
  endtask

  function automatic void arm_timer(int i);
    logic signed [50:0] e;
    e = $signed({3'b000, tstart[i]}) + tper[i];
    if (e < 0) texp[i] = '0;
    else if (e > $signed({3'b000, TMax})) texp[i] = TMax;
    else texp[i] = e[47:0];
    tina[i] = (tper[i] == -49'sd1);
    tstamp[i] = stamp_ctr;
    stamp_ctr++;
  endfunction

  function automatic int lookup_id(logic [31:0] id);
    if (id == 0) return -1;
    for (int i = 0; i < Slots; i++) if (tv[i] && tid[i] == id) return i;
    return -1;
  endfunction

  function automatic int earliest_timer();
    int h;
    h = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!tv[i] || tina[i]) continue;
      if (h < 0 || texp[i] < texp[h]) h = i;
      else if (texp[i] == texp[h] && (stamp_ctr - tstamp[i]) > (stamp_ctr - tstamp[h])) h = i;
    end
    return h;
  endfunction

  function automatic void push_rsp(logic [31:0] id, status_e s, logic signed [48:0] tl);
    timer_rsp_t r;
    r.rid = id; r.sts = s; r.tleft = tl; r.lst = 1'b1;
    expected_rsp.push_back(r);
  endfunction

  function automatic void predict_command(logic [2:0] f, logic [31:0] id, logic [47:0] now,
                                          logic signed [48:0] per, logic signed [31:0] reps,
                                          logic us);
    int i, cnt, n, h;
    timer_rsp_t r;
    case (cmd_e'(f))
      CMD_CREATE: begin
        for (i = 0; i < Slots; i++) if (!tv[i]) break;
        if (i >= Slots) push_rsp('0, STS_FULL, '0);
        else begin
          tv[i] = 1; tid[i] = id_next; tper[i] = per; treps[i] = reps; tstart[i] = now;
          arm_timer(i);
          push_rsp(id_next, STS_OK, '0);
          id_next++;
          if (id_next == 0) id_next = 1;
        end
      end
      CMD_DELETE, CMD_QUERY: begin
        i = lookup_id(id);
        if (i < 0) push_rsp('0, STS_NOT_FOUND, '0);
        else begin
          if (cmd_e'(f) == CMD_DELETE) tv[i] = 0;
          push_rsp(id, STS_OK, '0);
        end
      end
      CMD_SETLEN: begin
        i = lookup_id(id);
        if (i < 0) push_rsp('0, STS_NOT_FOUND, '0);
        else begin
          tper[i] = per;
          if (us) tstart[i] = now;
          arm_timer(i);
          push_rsp(id, STS_OK, '0);
        end
      end
      CMD_RUN: begin
        cnt = 0;
        for (i = 0; i < Slots; i++) if (tv[i] && !tina[i] && texp[i] <= now) cnt++;
        if (cnt > MaxFire) cnt = MaxFire;
        n = 0;
        while (n < cnt) begin
          h = earliest_timer();
          if (h < 0 || texp[h] > now) break;
          r.rid = tid[h]; r.sts = STS_OK; r.tleft = '0; r.lst = (n == cnt - 1);
          expected_rsp.push_back(r);
          tstart[h] = now;
          if (treps[h] == 0) tv[h] = 0;
          else begin
            if (treps[h] > 0) treps[h]--;
            arm_timer(h);
          end
          n++;
        end
        fired_total += n;
        if (n == 0) push_rsp('0, STS_NONE, '0);
        else expected_rsp[$].lst = 1'b1;
      end
      CMD_NEXT: begin
        h = earliest_timer();
        if (h < 0) push_rsp('0, STS_NONE, -49'sd1);
        else push_rsp('0, STS_OK, texp[h] > now ? {1'b0, texp[h] - now} : '0);
      end
      CMD_CLEAR: begin
        for (i = 0; i < Slots; i++) begin tv[i] = 0; tina[i] = 0; end
        push_rsp('0, STS_OK, '0);
      end
      default: push_rsp('0, STS_OK, '0);
    endcase
  endfunction

  task automatic send_cmd(input cmd_e f, input logic [31:0] id, input logic [47:0] now,
                          input logic signed [48:0] per, input logic signed [31:0] reps,
                          input logic us);
    // valid drops between requests
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= f; timer_id_i <= id; time_now_i <= now;
    period_length_i <= per; repeat_budget_i <= reps; use_start_i <= us;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(f, id, now, per, reps, us);
    n_reqs++;
    in_valid_i <= 1'b0;
  endtask

  // response checker and receiver stalls
  always @(posedge clk_i) begin
    timer_rsp_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_rsps++;
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result", result_id_o, status_o);
      end else begin
        w = expected_rsp.pop_front();
        if (result_id_o !== w.rid) report_mismatch("result_id", result_id_o, w.rid);
        if (status_o !== w.sts) report_mismatch("status", status_o, w.sts);
        if (time_left_o !== w.tleft) report_mismatch("time_left", time_left_o, w.tleft);
        if (last_o !== w.lst) report_mismatch("last", last_o, w.lst);
      end
    end
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic drain_rsps();
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_time();
    case ($urandom_range(3))
      0: return $urandom_range(200);
      1: return TMax - $urandom_range(200);
      default: return {$urandom, $urandom} & TMax;
    endcase
  endfunction

  function automatic logic signed [48:0] rand_len();
    case ($urandom_range(7))
      0: return -49'sd1;
      1: return -$signed(49'($urandom_range(100)));
      2: return {1'b1, $urandom, $urandom} & 49'h1_FFFF_FFFF_FFFF;
      3: return {1'b0, TMax};
      default: return $urandom_range(60);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_budget();
    case ($urandom_range(5))
      0: return -32'sd1;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom | 32'h8000_0000;
      default: return $urandom_range(3);
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(CMD_NEXT, 0, 0, 0, 0, 0);          // empty table
    send_cmd(CMD_RUN, 0, TMax, 0, 0, 0);        // nothing expired
    send_cmd(CMD_DELETE, 0, 0, 0, 0, 0);        // id zero
    send_cmd(CMD_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_cmd(CMD_SETLEN, 5, 0, 0, 0, 0);
    send_cmd(CMD_CREATE, 0, 10, 5, 0, 0);
    send_cmd(CMD_CREATE, 0, 10, 5, -1, 0);      // tie, forever
    send_cmd(CMD_CREATE, 0, 0, -49'sd1, 2, 0);  // inactive
    send_cmd(CMD_CREATE, 0, TMax, {1'b0, TMax}, 32'sh7FFF_FFFF, 1); // saturate high
    send_cmd(CMD_CREATE, 0, 3, -49'sh1_0000_0000_0000, 1, 0);       // saturate low
    send_cmd(CMD_NEXT, 0, 2, 0, 0, 0);
    send_cmd(CMD_RUN, 0, 15, 0, 0, 0);
    send_cmd(CMD_SETLEN, 3, 100, 7, 0, 1);
    send_cmd(CMD_SETLEN, 2, 100, -49'sd1, 0, 0);
    send_cmd(CMD_QUERY, 1, 0, 0, 0, 0);
    send_cmd(CMD_DELETE, 1, 0, 0, 0, 0);
    send_cmd(CMD_NOP, 32'hFFFF_FFFF, TMax, -49'sd1, -1, 1);
    for (int i = 0; i < 13; i++) send_cmd(CMD_CREATE, 0, 0, 0, 0, 0);
    send_cmd(CMD_CREATE, 0, 0, 0, 0, 0);        // table full
    send_cmd(CMD_RUN, 0, TMax, 0, 0, 0);        // fires every expired timer
    send_cmd(CMD_RUN, 0, TMax, 0, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0);
    drain_rsps();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    logic [47:0] base;
    cmd_e f;
    send_idle_pct = s_pct; recv_idle_pct = r_pct;
    base = $urandom_range(1000);
    for (int k = 0; k < count; k++) begin
      base += $urandom_range(20);
      case ($urandom_range(19))
        0, 1, 2, 3, 4:   f = CMD_CREATE;
        5, 6, 7, 8:      f = CMD_RUN;
        9, 10:           f = CMD_DELETE;
        11, 12:          f = CMD_SETLEN;
        13, 14:          f = CMD_NEXT;
        15, 16:          f = CMD_QUERY;
        17:              f = ($urandom_range(5) == 0) ? CMD_CLEAR : CMD_NOP;
        default:         f = cmd_e'($urandom_range(7));
      endcase
      send_cmd(f,
               ($urandom_range(9) == 0) ? $urandom : (id_next - $urandom_range(18)),
               ($urandom_range(7) == 0) ? rand_time() : base,
               rand_len(), rand_budget(), $urandom_range(1));
      if (k == count / 2) drain_rsps();   // let the queue run dry mid-phase
    end
    drain_rsps();
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin tv[i] = 0; tina[i] = 0; end
    id_next = 1; stamp_ctr = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150, 22, 61);
    test_random(150, 61, 22);
    test_random(150, 0, 0);
    $display("ran %0d commands, checked %0d results, %0d timer firings",
             n_reqs, n_rsps, fired_total);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
